// ===== design/mflq_pkg.sv =====
// mflq_pkg: shared constants, codes and types for the mesh floor level query block
// no dependencies; imported by the controller, datapath, top level and checker
`timescale 1ns / 1ps

package mflq_pkg;

  // store geometry
  localparam int MAX_TRIANGLES = 1024;
  localparam int COORD_BITS    = 32;
  localparam int TRI_AW        = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int TRI_CW        = $clog2(MAX_TRIANGLES + 1);

  // sum of three heights and the divide-by-three unit
  localparam int SUM_W     = COORD_BITS + 2;
  localparam int DIV_W     = COORD_BITS + 1;
  // floor(n / 3) == (n * DIV_RECIP) >> DIV_SHIFT for every DIV_W-bit n
  localparam int DIV_SHIFT = DIV_W + 1;
  localparam logic [DIV_W-1:0] DIV_RECIP =
      DIV_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
  // the multiplier takes the operand in two halves, one per cycle
  localparam int DIV_LO_W  = (DIV_W + 1) / 2;
  localparam int MUL_W     = DIV_LO_W + DIV_W;
  localparam int ACC_W     = 2 * DIV_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // input word commands
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE
  } state_t;

  // one stored vertex
  typedef struct packed {
    logic [COORD_BITS-1:0] z;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } vertex_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic query_start;
    logic scan_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic div_done;
  } dp_status_t;

endpackage

// ===== design/mflq_ctrl.sv =====
// mflq_ctrl: command decode, sequencing state machine and result valid register
// depends on mflq_pkg; drives mflq_datapath through dp_cmd_t
`timescale 1ns / 1ps

module mflq_ctrl
  import mflq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] command,
  output logic       result_valid,
  input  logic       result_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          unique case (command_t'(command))
            CMD_LOAD:  cmd.load = 1'b1;
            CMD_CLEAR: cmd.clear = 1'b1;
            CMD_QUERY: begin
              cmd.query_start = 1'b1;
              state_next      = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        // hand the result over once the output register is free
        if (status.div_done && (!result_valid || !result_stall)) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    result_valid_next = (result_valid && result_stall) || cmd.out_load;
  end

endmodule

// ===== design/mflq_datapath.sv =====
// mflq_datapath: vertex banks, mesh box, triangle scan pipeline, divide-by-three unit
// and result payload registers; depends on mflq_pkg, controlled by mflq_ctrl
`timescale 1ns / 1ps

module mflq_datapath
  import mflq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [COORD_BITS-1:0] coord_x,
  input  logic [COORD_BITS-1:0] coord_y,
  input  logic [COORD_BITS-1:0] coord_z,
  output logic                  found,
  output logic [COORD_BITS-1:0] floor_level
);

  function automatic logic signed [COORD_BITS-1:0] min3(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c
  );
    logic signed [COORD_BITS-1:0] m;
    begin
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
    end
  endfunction

  function automatic logic signed [COORD_BITS-1:0] max3(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c
  );
    logic signed [COORD_BITS-1:0] m;
    begin
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
    end
  endfunction

  // fill position: triangle index and vertex slot within it
  logic [TRI_CW-1:0] tri_count;
  logic [1:0]        phase;
  logic              full;
  logic              wr_en;

  logic signed [COORD_BITS-1:0] mesh_min_x, mesh_max_x, mesh_min_z, mesh_max_z;
  logic signed [COORD_BITS-1:0] in_x, in_z;

  // query point and scan state
  logic signed [COORD_BITS-1:0] qx, qz;
  logic                         mesh_hit;
  logic [TRI_CW-1:0]            rd_addr;
  logic                         issue;
  logic                         rd_valid;
  vertex_t                      bank_rd [3];

  logic signed [COORD_BITS-1:0] lox, hix, loz, hiz;
  logic signed [SUM_W-1:0]      ysum;
  logic                         s1_valid;
  logic                         tri_holds;

  logic                         hit;
  logic signed [SUM_W-1:0]      best;

  // divider
  logic [SUM_W-1:0]     best_mag;
  logic [DIV_W-1:0]     div_n;
  logic [ACC_W-1:0]     div_acc;
  logic [DIV_W-1:0]     div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_neg;
  logic                 div_first;
  logic [DIV_LO_W-1:0]  mul_a;
  logic [MUL_W-1:0]     mul_p;
  logic [DIV_W-1:0]     quo_signed;

  assign in_x  = coord_x;
  assign in_z  = coord_z;
  assign full  = (tri_count == TRI_CW'(MAX_TRIANGLES));
  assign wr_en = cmd.load && !full;
  assign issue = cmd.scan_en && mesh_hit && (rd_addr < tri_count);

  // fill counters and mesh box
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      tri_count  <= '0;
      phase      <= '0;
      mesh_min_x <= COORD_MAX;
      mesh_max_x <= COORD_MIN;
      mesh_min_z <= COORD_MAX;
      mesh_max_z <= COORD_MIN;
    end else if (wr_en) begin
      if (phase == 2'd2) begin
        phase     <= '0;
        tri_count <= tri_count + TRI_CW'(1);
      end else begin
        phase <= phase + 2'd1;
      end
      if (in_x < mesh_min_x) mesh_min_x <= in_x;
      if (in_x > mesh_max_x) mesh_max_x <= in_x;
      if (in_z < mesh_min_z) mesh_min_z <= in_z;
      if (in_z > mesh_max_z) mesh_max_z <= in_z;
    end
  end

  // three vertex banks, one per triangle corner, read side by side
  for (genvar b = 0; b < 3; b++) begin : gen_bank
    vertex_t bank_mem [MAX_TRIANGLES];

    always_ff @(posedge clk) begin
      if (wr_en && (phase == 2'(b))) begin
        bank_mem[tri_count[TRI_AW-1:0]] <= '{x: coord_x, y: coord_y, z: coord_z};
      end
      if (issue) begin
        bank_rd[b] <= bank_mem[rd_addr[TRI_AW-1:0]];
      end
    end
  end

  // query capture and read address
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx       <= in_x;
      qz       <= in_z;
      mesh_hit <= (in_x >= mesh_min_x) && (in_x <= mesh_max_x) &&
                  (in_z >= mesh_min_z) && (in_z <= mesh_max_z);
    end
    if (rst || cmd.query_start) begin
      rd_addr <= '0;
    end else if (issue) begin
      rd_addr <= rd_addr + TRI_CW'(1);
    end
  end

  // scan pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      s1_valid <= rd_valid;
    end
  end

  // stage 1: triangle box and height sum
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      lox  <= min3(bank_rd[0].x, bank_rd[1].x, bank_rd[2].x);
      hix  <= max3(bank_rd[0].x, bank_rd[1].x, bank_rd[2].x);
      loz  <= min3(bank_rd[0].z, bank_rd[1].z, bank_rd[2].z);
      hiz  <= max3(bank_rd[0].z, bank_rd[1].z, bank_rd[2].z);
      ysum <= SUM_W'($signed(bank_rd[0].y)) + SUM_W'($signed(bank_rd[1].y)) +
              SUM_W'($signed(bank_rd[2].y));
    end
  end

  // stage 2: point test and running minimum
  assign tri_holds = (qx >= lox) && (qx <= hix) && (qz >= loz) && (qz <= hiz);

  always_ff @(posedge clk) begin
    if (rst || cmd.query_start) begin
      hit <= 1'b0;
    end else if (s1_valid && tri_holds) begin
      hit <= 1'b1;
    end
    if (s1_valid && tri_holds && (!hit || (ysum < best))) begin
      best <= ysum;
    end
  end

  // divide by three on the magnitude, plus one for round to nearest,
  // as a reciprocal multiply over the low half and then the high half
  assign best_mag  = best[SUM_W-1] ? (~best + SUM_W'(1)) : best;
  assign div_first = (div_cnt == DIV_CNT_W'(DIV_STEPS));
  assign mul_a     = div_first ? div_n[DIV_LO_W-1:0] : DIV_LO_W'(div_n[DIV_W-1:DIV_LO_W]);
  assign mul_p     = MUL_W'(mul_a) * MUL_W'(DIV_RECIP);
  assign div_q     = DIV_W'(div_acc >> DIV_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (cmd.div_step && (div_cnt != '0)) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
    if (cmd.div_start) begin
      div_n   <= best_mag[DIV_W-1:0] + DIV_W'(1);
      div_neg <= best[SUM_W-1];
    end
    if (cmd.div_step && div_first) begin
      div_acc <= ACC_W'(mul_p);
    end else if (cmd.div_step && (div_cnt != '0)) begin
      div_acc <= div_acc + ACC_W'({mul_p, DIV_LO_W'(0)});
    end
  end

  // result payload
  assign quo_signed = div_neg ? (~div_q + DIV_W'(1)) : div_q;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= hit;
      floor_level <= hit ? quo_signed[COORD_BITS-1:0] : COORD_MIN;
    end
  end

  assign status.scan_done = !issue && !rd_valid && !s1_valid;
  assign status.div_done  = (div_cnt == '0);

endmodule

// ===== design/mesh_floor_level_query.sv =====
// mesh_floor_level_query: top level joining the controller and the datapath
// depends on mflq_pkg, mflq_ctrl and mflq_datapath
`timescale 1ns / 1ps

// Usage
// Input channel (item_valid / item_stall, command, coord_x, coord_y, coord_z):
//   a load vertex does not hold off the next word; every third vertex completes a triangle, and
//   loads beyond 3 * MAX_TRIANGLES vertices are dropped. A clear mesh does not
//   hold it off either. Neither gives a result word. Command 3 is taken and ignored.
// A query holds item_stall high while the scan and the divide run: the scan
//   reads one triangle a cycle from three vertex banks side by side (it is
//   skipped when the point lies outside the mesh box or no triangle is
//   complete), its pipeline drains, then a reciprocal multiply divides the
//   height sum by three, low half and then high half.
// Output channel (result_valid / result_stall, found, floor_level): one word
//   per query from an output register, valid in the cycle after the last
//   stalled input cycle. Loads and clears are still taken while a result
//   waits; a query finished under result_stall holds until the output
//   register frees up.
// Reset (rst, synchronous) empties the mesh and clears both channels; the
//   vertex banks are not cleared.
module mesh_floor_level_query
  import mflq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            command,
  input  logic [COORD_BITS-1:0] coord_x,
  input  logic [COORD_BITS-1:0] coord_y,
  input  logic [COORD_BITS-1:0] coord_z,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  found,
  output logic [COORD_BITS-1:0] floor_level
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  mflq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // storage and arithmetic
  mflq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .found       (found),
    .floor_level (floor_level)
  );

endmodule

// ===== design/mflq_checker.sv =====
// mflq_checker: port-level assertions for mesh_floor_level_query, bound to the top level
// depends on mflq_pkg
`timescale 1ns / 1ps

module mflq_checker
  import mflq_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input logic [1:0]            command,
  input logic                  result_valid,
  input logic                  result_stall,
  input logic                  found,
  input logic [COORD_BITS-1:0] floor_level
);

  // a stalled result word stays valid
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped under stall");

  // a stalled result word keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(found) && $stable(floor_level))
    else $error("result payload changed under stall");

  // a miss always reports the most negative level
  a_miss_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> floor_level == COORD_MIN)
    else $error("miss without most negative floor level");

  // an accepted query holds off the input channel while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == CMD_QUERY) |=> item_stall)
    else $error("input taken during a query");

  // loads, clears and unused commands never stall the next word
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command != CMD_QUERY) |=> !item_stall)
    else $error("input stalled after a one-cycle command");

endmodule

bind mesh_floor_level_query mflq_checker u_mflq_checker (.*);

// ===== dv/tb_mesh_floor_level_query.sv =====
// tb_mesh_floor_level_query: self-checking bench for the mesh floor level query block
// depends on mflq_pkg and mesh_floor_level_query; stimulus, prediction and checks are local
`timescale 1ns / 1ps

module tb_mesh_floor_level_query;
  import mflq_pkg::*;

  localparam int STORE_DEPTH = 3 * MAX_TRIANGLES;
  localparam int HANG_LIMIT  = 4 * (MAX_TRIANGLES + 64);
  localparam int ONE         = 1 << 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } word_t;

  typedef struct {
    logic                  found;
    logic [COORD_BITS-1:0] level;
  } floor_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [1:0]            command = CMD_LOAD;
  logic [COORD_BITS-1:0] coord_x = '0;
  logic [COORD_BITS-1:0] coord_y = '0;
  logic [COORD_BITS-1:0] coord_z = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  found;
  logic [COORD_BITS-1:0] floor_level;

  mesh_floor_level_query i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .floor_level  (floor_level)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // words waiting to be sent, and floor levels the block still owes
  word_t  words_to_send[$];
  floor_t floor_levels_due[$];
  word_t  on_bus;
  int     words_queued = 0;
  int     results_seen = 0;
  int     mismatches = 0;
  int     idle_run = 0;
  wire    calm = (results_seen >= 40) && (results_seen < 80);

  // predicted mesh contents
  logic signed [COORD_BITS-1:0] vtx_x[STORE_DEPTH];
  logic signed [COORD_BITS-1:0] vtx_y[STORE_DEPTH];
  logic signed [COORD_BITS-1:0] vtx_z[STORE_DEPTH];
  int                           vtx_count;
  logic signed [COORD_BITS-1:0] box_lo_x, box_hi_x, box_lo_z, box_hi_z;

  // vertex coordinates as queued, used only to aim query points
  int gen_x[$];
  int gen_z[$];

  function automatic void clear_mesh();
    vtx_count = 0;
    box_lo_x  = COORD_MAX;
    box_hi_x  = COORD_MIN;
    box_lo_z  = COORD_MAX;
    box_hi_z  = COORD_MIN;
  endfunction

  // update the mesh for one accepted word; a query owes one floor level
  function automatic void predict_floor(input word_t w);
    logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_z, hi_z;
    longint                       sum, best, q;
    logic                         hit;
    int                           b;
    floor_t                       res;
    hit  = 1'b0;
    best = 0;
    case (w.cmd)
      CMD_LOAD: begin
        if (vtx_count < STORE_DEPTH) begin
          vtx_x[vtx_count] = w.x;
          vtx_y[vtx_count] = w.y;
          vtx_z[vtx_count] = w.z;
          vtx_count++;
          if (w.x < box_lo_x) box_lo_x = w.x;
          if (w.x > box_hi_x) box_hi_x = w.x;
          if (w.z < box_lo_z) box_lo_z = w.z;
          if (w.z > box_hi_z) box_hi_z = w.z;
        end
      end
      CMD_CLEAR: clear_mesh();
      CMD_QUERY: begin
        if (w.x >= box_lo_x && w.x <= box_hi_x && w.z >= box_lo_z && w.z <= box_hi_z) begin
          for (int t = 0; t < vtx_count / 3; t++) begin
            b    = 3 * t;
            lo_x = vtx_x[b];
            hi_x = lo_x;
            lo_z = vtx_z[b];
            hi_z = lo_z;
            for (int k = 1; k < 3; k++) begin
              if (vtx_x[b + k] < lo_x) lo_x = vtx_x[b + k];
              if (vtx_x[b + k] > hi_x) hi_x = vtx_x[b + k];
              if (vtx_z[b + k] < lo_z) lo_z = vtx_z[b + k];
              if (vtx_z[b + k] > hi_z) hi_z = vtx_z[b + k];
            end
            if (w.x >= lo_x && w.x <= hi_x && w.z >= lo_z && w.z <= hi_z) begin
              sum = longint'(vtx_y[b]) + longint'(vtx_y[b + 1]) + longint'(vtx_y[b + 2]);
              if (!hit || sum < best) best = sum;
              hit = 1'b1;
            end
          end
        end
        res.found = hit;
        if (hit) begin
          // divide by three, rounding to nearest
          q = (best >= 0) ? (best + 1) / 3 : -((1 - best) / 3);
          res.level = q[COORD_BITS-1:0];
        end else begin
          res.level = COORD_MIN;
        end
        floor_levels_due.insert(floor_levels_due.size(), res);
      end
      default: ;
    endcase
  endfunction

  // stimulus helpers
  task automatic push_word(input logic [1:0] c, input int x, input int y, input int z);
    word_t w;
    w.cmd = c;
    w.x   = x;
    w.y   = y;
    w.z   = z;
    words_to_send.insert(words_to_send.size(), w);
    if (c != CMD_UNUSED) words_queued++;
    if (c == CMD_LOAD && gen_x.size() < STORE_DEPTH) begin
      gen_x.insert(gen_x.size(), x);
      gen_z.insert(gen_z.size(), z);
    end else if (c == CMD_CLEAR) begin
      gen_x.delete();
      gen_z.delete();
    end
  endtask

  function automatic int jitter(input int centre, input int spread);
    return centre + int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic int height();
    return ($urandom_range(4) == 0) ? int'($urandom) : jitter(0, 1 << 20);
  endfunction

  // a point on, just off, or inside the range lo..hi
  function automatic int pick_in(input int lo, input int hi);
    longint span;
    span = longint'(hi) - longint'(lo) + 1;
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      default: return int'(longint'(lo) + longint'($urandom) % span);
    endcase
  endfunction

  // vertices scattered around one center, so triangle boxes overlap
  task automatic queue_cluster(input int tris, input int extra);
    int cx, cz, spread;
    cx     = ($urandom_range(9) == 0) ? int'($urandom) : jitter(0, 1 << 20);
    cz     = ($urandom_range(9) == 0) ? int'($urandom) : jitter(0, 1 << 20);
    spread = 1 << $urandom_range(2, 20);
    for (int i = 0; i < 3 * tris + extra; i++) begin
      push_word(CMD_LOAD, jitter(cx, spread), height(), jitter(cz, spread));
    end
  endtask

  // aim 0: inside or around one triangle box; 1: vertex coordinates; 2: anywhere
  task automatic queue_query(input int aim);
    int tris, b, lo_x, hi_x, lo_z, hi_z, px, pz;
    px   = $urandom;
    pz   = $urandom;
    tris = gen_x.size() / 3;
    if (aim == 0 && tris > 0) begin
      b    = 3 * $urandom_range(tris - 1);
      lo_x = gen_x[b];
      hi_x = lo_x;
      lo_z = gen_z[b];
      hi_z = lo_z;
      for (int k = 1; k < 3; k++) begin
        if (gen_x[b + k] < lo_x) lo_x = gen_x[b + k];
        if (gen_x[b + k] > hi_x) hi_x = gen_x[b + k];
        if (gen_z[b + k] < lo_z) lo_z = gen_z[b + k];
        if (gen_z[b + k] > hi_z) hi_z = gen_z[b + k];
      end
      px = pick_in(lo_x, hi_x);
      pz = pick_in(lo_z, hi_z);
    end else if (aim == 1 && gen_x.size() > 0) begin
      px = gen_x[$urandom_range(gen_x.size() - 1)];
      pz = gen_z[$urandom_range(gen_z.size() - 1)];
    end
    push_word(CMD_QUERY, px, $urandom, pz);
  endtask

  // input side: offer the next word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) predict_floor(on_bus);
      if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
        on_bus = words_to_send.pop_front();
        item_valid <= 1'b1;
        command    <= on_bus.cmd;
        coord_x    <= on_bus.x;
        coord_y    <= on_bus.y;
        coord_z    <= on_bus.z;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // output side: random stall, compare each result word, watch for a hang
  always @(posedge clk) begin
    floor_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 13);
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (floor_levels_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, found=%0b floor_level=%h",
                   $time, found, floor_level);
        end else begin
          want = floor_levels_due.pop_front();
          if (found !== want.found) begin
            mismatches++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
          end
          if (floor_level !== want.level) begin
            mismatches++;
            $display("%0t: floor_level expected %h actual %h", $time, want.level, floor_level);
          end
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        idle_run <= 0;
      end else if (idle_run >= HANG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_run);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    int start;
    clear_mesh();

    // empty mesh, then two trailing vertices with no complete triangle
    push_word(CMD_QUERY, 0, 0, 0);
    push_word(CMD_LOAD, 0, 3 * ONE, 0);
    push_word(CMD_LOAD, 2 * ONE, 4 * ONE, 2 * ONE);
    push_word(CMD_QUERY, ONE, 0, ONE);
    // first triangle, inclusive corner hit and a point just off the mesh box
    push_word(CMD_LOAD, ONE, 5 * ONE, 0);
    push_word(CMD_QUERY, 2 * ONE, 0, 2 * ONE);
    push_word(CMD_QUERY, 2 * ONE + 1, 0, ONE);
    // lower triangle over the same box, negative sum rounds away from zero
    push_word(CMD_LOAD, 0, -1, 0);
    push_word(CMD_LOAD, 2 * ONE, -1, 0);
    push_word(CMD_LOAD, 0, 0, 2 * ONE);
    push_word(CMD_QUERY, ONE, -1, ONE);
    // full-range triangle at the most negative height
    push_word(CMD_LOAD, int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN));
    push_word(CMD_LOAD, int'(COORD_MAX), int'(COORD_MIN), int'(COORD_MAX));
    push_word(CMD_LOAD, int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MAX));
    push_word(CMD_QUERY, int'(COORD_MAX), 0, int'(COORD_MIN));
    push_word(CMD_QUERY, int'(COORD_MIN), int'(COORD_MAX), int'(COORD_MAX));
    // unused command is dropped
    push_word(CMD_UNUSED, -1, -1, -1);
    push_word(CMD_UNUSED, 0, 0, 0);
    // clear, then a single-point triangle at the most positive height
    push_word(CMD_CLEAR, -1, -1, -1);
    push_word(CMD_QUERY, 0, 0, 0);
    push_word(CMD_LOAD, int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX));
    push_word(CMD_LOAD, int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX));
    push_word(CMD_LOAD, int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX));
    push_word(CMD_QUERY, int'(COORD_MAX), 0, int'(COORD_MAX));
    push_word(CMD_QUERY, int'(COORD_MAX) - 1, 0, int'(COORD_MAX));

    // fill the store, then two loads that must be dropped
    push_word(CMD_CLEAR, 0, 0, 0);
    queue_cluster(MAX_TRIANGLES, 0);
    push_word(CMD_LOAD, int'(COORD_MAX), int'(COORD_MIN), int'(COORD_MAX));
    push_word(CMD_LOAD, int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN));
    queue_query(0);
    queue_query(0);
    queue_query(2);
    push_word(CMD_CLEAR, 0, 0, 0);

    // random meshes built up in clusters, with queries aimed at them
    start = words_queued;
    while (words_queued - start < 400) begin
      if ($urandom_range(99) < 25 || gen_x.size() > 600) begin
        push_word(CMD_CLEAR, $urandom, $urandom, $urandom);
      end
      queue_cluster($urandom_range(1, 6), ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
      repeat ($urandom_range(1, 6)) begin
        queue_query(($urandom_range(9) < 6) ? 0 : $urandom_range(1, 2));
      end
      if ($urandom_range(9) == 0) push_word(CMD_UNUSED, $urandom, $urandom, $urandom);
      if ($urandom_range(19) == 0) push_word(CMD_LOAD, $urandom, $urandom, $urandom);
    end

    // drain: everything sent, every floor level back, then a short quiet spell
    do @(negedge clk); while (rst || words_to_send.size() != 0 || item_valid);
    while (floor_levels_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
